@@ design/bounded_indexed_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Bounded indexed queue: assertion macros
// Shared concurrent assertion forms, sampled on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INDEXED_QUEUE_DEFINES_SVH
`define BOUNDED_INDEXED_QUEUE_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset
`define BIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define BIQ_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ design/biq_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded indexed queue package
// Sizes, operation and status codes, and the command/response structs.
// ----------------------------------------------------------------------------
package biq_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(16);

  // Operation codes
  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_INSERT     = 3'd3,
    MODE_ERASE      = 3'd4,
    MODE_READ       = 3'd5,
    MODE_QUERY      = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                     mode;
    logic [CNT_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic [CNT_W-1:0]          count;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

endpackage

@@ design/biq_if.sv @@
// ----------------------------------------------------------------------------
// Bounded indexed queue channels
// Valid/ready command and response channels with flat payload fields.
// ----------------------------------------------------------------------------
interface biq_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [4:0]         position;
  logic signed [31:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink (input valid, mode, position, value, output ready);
endinterface

interface biq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data_out;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic [4:0]         count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, status, data_out, front_value, rear_value, count,
                  is_empty, is_full, input ready);
  modport sink (input valid, status, data_out, front_value, rear_value, count,
                is_empty, is_full, output ready);
endinterface

@@ design/biq_in_stage.sv @@
// ----------------------------------------------------------------------------
// Bounded indexed queue input stage
// Registers one command; refills in the same cycle it hands one on.
// ----------------------------------------------------------------------------
module biq_in_stage import biq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t cmd_i,
  input  logic advance_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;

  // Take a new transfer when empty or when the held command moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

@@ design/biq_core.sv @@
// ----------------------------------------------------------------------------
// Bounded indexed queue core
// Entry register array and count; applies one operation per step.
// ----------------------------------------------------------------------------
`include "bounded_indexed_queue_defines.svh"

module biq_core import biq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cmd_t             cmd_i,
  input  logic [CNT_W-1:0] limit_i,
  output rsp_t             rsp_o
);

  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic signed [DATA_W-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         eff_limit;
  logic                     full;
  logic [CNT_W-1:0]         ins_pos;
  logic                     do_insert;
  logic                     do_erase;
  status_e                  status;
  logic signed [DATA_W-1:0] data;

  // Effective limit is capped at the store depth
  assign eff_limit = (limit_i > DEPTH_CNT) ? DEPTH_CNT : limit_i;
  assign full      = count_q >= eff_limit;

  // Decode the operation and check it
  always_comb begin
    status    = ST_OK;
    data      = '0;
    do_insert = 1'b0;
    do_erase  = 1'b0;
    ins_pos   = cmd_i.position;
    case (cmd_i.mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
        if (cmd_i.mode == MODE_PUSH_BACK) begin
          ins_pos = count_q;
        end else if (cmd_i.mode == MODE_PUSH_FRONT) begin
          ins_pos = '0;
        end
        if (full || count_q >= DEPTH_CNT) begin
          status = ST_FULL;
        end else if (cmd_i.mode == MODE_INSERT && cmd_i.position > count_q) begin
          status = ST_RANGE;
        end else begin
          do_insert = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        ins_pos = '0;
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          do_erase = 1'b1;
          data     = entries_q[0];
        end
      end
      MODE_ERASE, MODE_READ: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (cmd_i.position >= count_q) begin
          status = ST_RANGE;
        end else begin
          do_erase = (cmd_i.mode == MODE_ERASE);
          data     = entries_q[cmd_i.position[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  // Next store contents: shift up to open a slot, or down to close one
  always_comb begin
    count_d   = count_q;
    entries_d = entries_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) == ins_pos) begin
          entries_d[IDX_W'(i)] = cmd_i.value;
        end else if (CNT_W'(i) > ins_pos && i > 0) begin
          entries_d[IDX_W'(i)] = entries_q[IDX_W'(i-1)];
        end
      end
    end else if (do_erase) begin
      count_d = count_q - CNT_W'(1);
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (CNT_W'(i) >= ins_pos) begin
          entries_d[IDX_W'(i)] = entries_q[IDX_W'(i+1)];
        end
      end
    end else if (cmd_i.mode == MODE_CLEAR) begin
      count_d = '0;
    end
  end

  // Result describes the store after the operation
  always_comb begin
    rsp_o.status      = status;
    rsp_o.data_out    = data;
    rsp_o.front_value = (count_d != '0) ? entries_d[0] : '1;
    rsp_o.rear_value  = (count_d != '0) ? entries_d[IDX_W'(count_d - CNT_W'(1))] : '1;
    rsp_o.count       = count_d;
    rsp_o.is_empty    = (count_d == '0);
    rsp_o.is_full     = (count_d >= eff_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      entries_q <= entries_d;
    end
  end

  // Checks
  `BIQ_ASSERT(a_count_bound, count_q <= DEPTH_CNT, "count exceeds depth")
  `BIQ_ASSERT_NEXT(a_clear, step_i && cmd_i.mode == MODE_CLEAR, count_q == '0, "clear kept entries")
  `BIQ_ASSERT_NEXT(a_refused, step_i && status != ST_OK, $stable(count_q), "refusal moved count")
  `BIQ_ASSERT_NEXT(a_insert, step_i && do_insert, count_q == $past(count_q) + CNT_W'(1), "insert")

endmodule

@@ design/bounded_indexed_queue.sv @@
// Bounded indexed queue: an ordered store of up to 16 signed 32-bit entries.
// Commands arrive on cmd_i (mode, position, value); every command gives one
// response on rsp_o with status, removed/read data, front and rear entries,
// count and empty/full flags describing the store after the command.
// cfg_we_i/cfg_wdata_i set the capacity limit; write it only while idle.
// Throughput: one command per cycle while the receiver takes responses. An
// accepted command is applied when it leaves the input register, and its
// response is then loaded into the output register and shown from then on.
// Insert and erase shift the entry register array at once: this sets the rate.
// Reset clears the store to empty, sets the limit to 16 and drops both
// pipeline stages; cmd_i.ready is high right after reset.
// When the receiver stalls, the response holds in the output register, one
// more command waits in the input register, and then cmd_i.ready falls.
// ----------------------------------------------------------------------------
// Bounded indexed queue top level
// Input register, store core, output register and capacity register.
// ----------------------------------------------------------------------------
module bounded_indexed_queue import biq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  biq_cmd_if.sink          cmd_i,
  biq_rsp_if.source        rsp_o
);

  logic             s1_valid;
  cmd_t             s1_cmd;
  cmd_t             in_cmd;
  logic             advance;
  rsp_t             core_rsp;
  rsp_t             rsp_q;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] limit_q;

  assign in_cmd.mode     = mode_e'(cmd_i.mode);
  assign in_cmd.position = cmd_i.position;
  assign in_cmd.value    = cmd_i.value;

  // Command moves on when the output register is free or being drained
  assign advance = s1_valid && (!out_valid_q || rsp_o.ready);

  biq_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .cmd_i      (in_cmd),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .cmd_o      (s1_cmd)
  );

  biq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cmd_i   (s1_cmd),
    .limit_i (limit_q),
    .rsp_o   (core_rsp)
  );

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= core_rsp;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.data_out    = rsp_q.data_out;
  assign rsp_o.front_value = rsp_q.front_value;
  assign rsp_o.rear_value  = rsp_q.rear_value;
  assign rsp_o.count       = rsp_q.count;
  assign rsp_o.is_empty    = rsp_q.is_empty;
  assign rsp_o.is_full     = rsp_q.is_full;

endmodule
